// ===== hw/rtl/dthx_pkg.sv =====
// shared types, character codes and helpers for the double to hex text formatter
package dthx_pkg;

  localparam int FracDigits = 13;
  localparam int FracBits   = 4 * FracDigits;

  localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;
  localparam logic [10:0] EXP_BIAS     = 11'd1023;
  localparam logic [9:0]  EXP_SUB_MAG  = 10'd1022;

  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_PLUS  = 7'h2B;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_ONE   = 7'h31;
  localparam logic [6:0] CH_X     = 7'h78;
  localparam logic [6:0] CH_DOT   = 7'h2E;
  localparam logic [6:0] CH_P     = 7'h50;

  localparam logic [3:0] NAN_LAST_IDX = 4'd2;
  localparam logic [3:0] INF_LAST_IDX = 4'd7;

  typedef enum logic [1:0] {
    KIND_NUM,
    KIND_NAN,
    KIND_INF
  } kind_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_SIGN,
    PH_ZERO,
    PH_X,
    PH_LEAD,
    PH_DOT,
    PH_FRAC,
    PH_P,
    PH_ESIGN,
    PH_ETH,
    PH_EHU,
    PH_ETE,
    PH_EUN,
    PH_NAN,
    PH_INF
  } phase_t;

  // everything the serializer needs to spell out one value
  typedef struct packed {
    kind_t               kind;
    logic                neg;
    logic                lead;
    logic [FracBits-1:0] frac;
    logic [3:0]          kept;
    logic                exp_neg;
    logic                exp_th;
    logic [3:0]          exp_hu;
    logic [6:0]          exp_lo;
    logic [2:0]          exp_ndig;
  } fmt_t;

  function automatic logic [6:0] hex_char(input logic [3:0] d);
    if (d < 4'd10) begin
      hex_char = CH_ZERO | {3'b000, d};
    end else begin
      hex_char = 7'h37 + {3'b000, d};
    end
  endfunction

  function automatic logic [6:0] nan_char(input logic [3:0] idx);
    case (idx)
      4'd0:    nan_char = 7'h4E;
      4'd1:    nan_char = 7'h61;
      default: nan_char = 7'h4E;
    endcase
  endfunction

  function automatic logic [6:0] inf_char(input logic [3:0] idx);
    case (idx)
      4'd0:    inf_char = 7'h69;
      4'd1:    inf_char = 7'h6E;
      4'd2:    inf_char = 7'h66;
      4'd3:    inf_char = 7'h69;
      4'd4:    inf_char = 7'h6E;
      4'd5:    inf_char = 7'h69;
      4'd6:    inf_char = 7'h74;
      default: inf_char = 7'h79;
    endcase
  endfunction

endpackage

// ===== hw/rtl/dthx_format.sv =====
// splits a double into the fields of its hex text: kind, digits, trim count, exponent digits
module dthx_format (
  input  logic [63:0]         value_bits,
  output dthx_pkg::fmt_t      fmt
);
  import dthx_pkg::*;

  logic        sign;
  logic [10:0] expf;
  logic [51:0] frac;
  logic [9:0]  mag;
  logic        e_neg;
  logic        th;
  logic [9:0]  rem;
  logic [15:0] hu_prod;
  logic [3:0]  hu;
  logic [9:0]  hu_x;
  logic [3:0]  kept;

  assign sign = value_bits[63];
  assign expf = value_bits[62:52];
  assign frac = value_bits[51:0];

  // unbiased exponent magnitude, subnormals pinned at -1022
  always_comb begin
    if (expf == 11'd0) begin
      mag   = EXP_SUB_MAG;
      e_neg = 1'b1;
    end else if (expf >= EXP_BIAS) begin
      mag   = 10'(expf - EXP_BIAS);
      e_neg = 1'b0;
    end else begin
      mag   = 10'(EXP_BIAS - expf);
      e_neg = 1'b1;
    end
  end

  // decimal split: magnitude never exceeds 1024 (1023 for finite values) so the thousands digit is 0 or 1
  assign th      = mag >= 10'd1000;
  assign rem     = th ? 10'(mag - 10'd1000) : mag;
  assign hu_prod = 16'(rem) * 16'd41;
  assign hu      = hu_prod[15:12];
  assign hu_x    = 10'(hu) * 10'd100;

  // trailing zero trim, at least one digit stays
  always_comb begin
    kept = 4'd1;
    for (int i = 0; i < FracDigits; i++) begin
      if (frac[FracBits-1-4*i -: 4] != 4'd0) begin
        kept = 4'(i + 1);
      end
    end
  end

  always_comb begin
    if (expf == EXP_ALL_ONES) begin
      fmt.kind = (frac != 52'd0) ? KIND_NAN : KIND_INF;
    end else begin
      fmt.kind = KIND_NUM;
    end
    fmt.neg      = sign;
    fmt.lead     = expf != 11'd0;
    fmt.frac     = frac;
    fmt.kept     = kept;
    fmt.exp_neg  = e_neg;
    fmt.exp_th   = th;
    fmt.exp_hu   = hu;
    fmt.exp_lo   = 7'(rem - hu_x);
    if (th) begin
      fmt.exp_ndig = 3'd4;
    end else if (mag >= 10'd100) begin
      fmt.exp_ndig = 3'd3;
    end else if (mag >= 10'd10) begin
      fmt.exp_ndig = 3'd2;
    end else begin
      fmt.exp_ndig = 3'd1;
    end
  end

endmodule

// ===== hw/rtl/dthx_serial.sv =====
// character sequencer and output register: walks the text of one value a character a cycle while the receiver accepts
module dthx_serial (
  input  logic             clk,
  input  logic             rst,
  input  dthx_pkg::fmt_t   fmt,
  input  logic             fmt_valid,
  output logic             fmt_take,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,   // [6:0] text_char, [7] zero
  output logic             m_tlast    // last_char
);
  import dthx_pkg::*;

  phase_t              phase;
  phase_t              phase_next;
  phase_t              start_phase;
  fmt_t                item;
  logic [FracBits-1:0] frac_sh;
  logic [3:0]          fcount;
  logic [3:0]          sidx;

  logic                advance;
  logic                emit;
  logic                cur_last;
  logic [6:0]          cur_char;
  logic                load;
  logic [14:0]         lo_prod;
  logic [3:0]          tens;
  logic [6:0]          ten_x;
  logic [3:0]          units;

  // tens and units of the low two exponent digits
  assign lo_prod = 15'(item.exp_lo) * 15'd205;
  assign tens    = lo_prod[14:11];
  assign ten_x   = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
  assign units   = 4'(item.exp_lo - ten_x);

  assign advance  = !m_tvalid || m_tready;
  assign emit     = phase != PH_IDLE;
  assign fmt_take = advance && (!emit || cur_last);
  assign load     = fmt_take && fmt_valid;

  always_comb begin
    unique case (fmt.kind)
      KIND_NAN: start_phase = PH_NAN;
      KIND_INF: start_phase = fmt.neg ? PH_SIGN : PH_INF;
      default:  start_phase = fmt.neg ? PH_SIGN : PH_ZERO;
    endcase
  end

  always_comb begin
    cur_char   = CH_ZERO;
    cur_last   = 1'b0;
    phase_next = phase;
    unique case (phase)
      PH_IDLE: begin
        phase_next = PH_IDLE;
      end
      PH_SIGN: begin
        cur_char   = CH_MINUS;
        phase_next = (item.kind == KIND_INF) ? PH_INF : PH_ZERO;
      end
      PH_ZERO: begin
        cur_char   = CH_ZERO;
        phase_next = PH_X;
      end
      PH_X: begin
        cur_char   = CH_X;
        phase_next = PH_LEAD;
      end
      PH_LEAD: begin
        cur_char   = item.lead ? CH_ONE : CH_ZERO;
        phase_next = PH_DOT;
      end
      PH_DOT: begin
        cur_char   = CH_DOT;
        phase_next = PH_FRAC;
      end
      PH_FRAC: begin
        cur_char   = hex_char(frac_sh[FracBits-1 -: 4]);
        phase_next = (fcount == 4'd1) ? PH_P : PH_FRAC;
      end
      PH_P: begin
        cur_char   = CH_P;
        phase_next = PH_ESIGN;
      end
      PH_ESIGN: begin
        cur_char = item.exp_neg ? CH_MINUS : CH_PLUS;
        case (item.exp_ndig)
          3'd4:    phase_next = PH_ETH;
          3'd3:    phase_next = PH_EHU;
          3'd2:    phase_next = PH_ETE;
          default: phase_next = PH_EUN;
        endcase
      end
      PH_ETH: begin
        cur_char   = CH_ZERO | {6'd0, item.exp_th};
        phase_next = PH_EHU;
      end
      PH_EHU: begin
        cur_char   = hex_char(item.exp_hu);
        phase_next = PH_ETE;
      end
      PH_ETE: begin
        cur_char   = hex_char(tens);
        phase_next = PH_EUN;
      end
      PH_EUN: begin
        cur_char   = hex_char(units);
        cur_last   = 1'b1;
        phase_next = PH_IDLE;
      end
      PH_NAN: begin
        cur_char   = nan_char(sidx);
        cur_last   = sidx == NAN_LAST_IDX;
        phase_next = cur_last ? PH_IDLE : PH_NAN;
      end
      PH_INF: begin
        cur_char   = inf_char(sidx);
        cur_last   = sidx == INF_LAST_IDX;
        phase_next = cur_last ? PH_IDLE : PH_INF;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= emit;
      if (load) begin
        phase <= start_phase;
      end else begin
        phase <= phase_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (emit) begin
        m_tdata <= {1'b0, cur_char};
        m_tlast <= cur_last;
      end
      if (load) begin
        item    <= fmt;
        frac_sh <= fmt.frac;
        fcount  <= fmt.kept;
        sidx    <= 4'd0;
      end else begin
        if (phase == PH_FRAC) begin
          frac_sh <= {frac_sh[FracBits-5:0], 4'd0};
          fcount  <= fcount - 4'd1;
        end
        if (phase == PH_NAN || phase == PH_INF) begin
          sidx <= sidx + 4'd1;
        end
      end
    end
  end

  a_frac_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_FRAC |-> (fcount != 4'd0 && fcount <= 4'd13))
    else $error("fraction digit count out of range");

  a_text_index: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_NAN |-> sidx <= NAN_LAST_IDX) and (phase == PH_INF |-> sidx <= INF_LAST_IDX))
    else $error("special text index past its end");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    (advance && emit) |=> m_tvalid)
    else $error("emitted character not presented");

  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    (advance && emit && cur_last && !load) |=> phase == PH_IDLE)
    else $error("sequencer did not stop after last character");

endmodule

// ===== hw/rtl/double_to_hex_text.sv =====
// top level: formats IEEE 754 doubles as hexadecimal ascii text, one character per transaction
//
// input channel s_*: one transaction carries the 64 raw bits of a double.
// output channel m_*: one transaction per character; m_tlast marks the final
// character of a value's text. a value yields 3 to 24 characters.
// text: optional '-', "0x", leading digit, '.', upper-case fraction digits with
// trailing zeros trimmed (one kept), 'P', exponent sign and decimal exponent;
// NaN gives "NaN", infinities give "infinity" or "-infinity".
// path: the first character passes the input register, the sequencer state and the
// output register before it is presented; the rest follow one per cycle while accepted.
// throughput: one character per cycle while the receiver accepts, set by the single
// output port; the next value's text follows the last character of the previous
// one without a gap when the next value already waits in the input register.
// an input register holds the next value while the current one is spelled out.
// reset: rst clears the input and output valid flags and the sequencer.
// when the receiver stalls the current character holds and the sequencer waits;
// the input side stalls once its register is full.
module double_to_hex_text (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [63:0] value_bits
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [6:0] text_char, [7] zero
  output logic        m_tlast    // last_char
);
  import dthx_pkg::*;

  logic        in_valid;
  logic [63:0] in_bits;
  fmt_t        fmt;
  logic        fmt_take;

  assign s_tready = !in_valid || fmt_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_bits <= s_tdata;
    end
  end

  dthx_format u_format (
    .value_bits (in_bits),
    .fmt        (fmt)
  );

  dthx_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .fmt       (fmt),
    .fmt_valid (in_valid),
    .fmt_take  (fmt_take),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

// ===== test/double_to_hex_text_tb.sv =====
// self-checking testbench for the double to hex text formatter
`timescale 1ns / 1ps

module double_to_hex_text_tb;

  typedef struct {
    logic [6:0] ch;
    logic       last;
  } text_beat_t;

  typedef struct {
    logic [63:0] bits;
    string       text;  // empty: ask the text predictor
  } fmt_row_t;

  typedef enum int {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_t;

  localparam int RandomItems  = 480;
  localparam int HoldStart    = 3000;
  localparam int HoldCycles   = 600;
  localparam int DrainCycles  = 30;
  localparam int ExpBias      = 1023;
  localparam int ExpSubnormal = -1022;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = 64'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  text_beat_t pending_chars[$];
  fmt_row_t   directed_rows[$];
  int         error_count = 0;

  double_to_hex_text dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    $display("error at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic void push_text(input string s);
    text_beat_t beat;
    byte        b;
    for (int i = 0; i < s.len(); i++) begin
      b         = s[i];
      beat.ch   = b[6:0];
      beat.last = (i == s.len() - 1);
      pending_chars.push_back(beat);
    end
  endfunction

  // spells out one double the way the formatter should
  function automatic void spell_value(input logic [63:0] bits);
    string       hex_glyphs;
    string       txt;
    logic        sign;
    logic [10:0] expf;
    logic [51:0] frac;
    int          kept;
    int          ex;
    int          mag;
    int          digit;
    hex_glyphs = "0123456789ABCDEF";
    sign = bits[63];
    expf = bits[62:52];
    frac = bits[51:0];
    if (expf == dthx_pkg::EXP_ALL_ONES) begin
      if (frac != 52'd0) txt = "NaN";
      else if (sign) txt = "-infinity";
      else txt = "infinity";
    end else begin
      if (sign) txt = "-0x";
      else txt = "0x";
      if (expf == 11'd0) txt = {txt, "0."};
      else txt = {txt, "1."};
      kept = 13;
      while (kept > 1 && frac[4 * (13 - kept) +: 4] == 4'd0) kept--;
      for (int i = 0; i < kept; i++) begin
        digit = int'(frac[4 * (12 - i) +: 4]);
        txt   = {txt, hex_glyphs.substr(digit, digit)};
      end
      ex  = (expf == 11'd0) ? ExpSubnormal : int'(expf) - ExpBias;
      mag = (ex < 0) ? -ex : ex;
      if (ex < 0) txt = {txt, $sformatf("P-%0d", mag)};
      else txt = {txt, $sformatf("P+%0d", mag)};
    end
    push_text(txt);
  endfunction

  function automatic void add_row(input logic [63:0] bits, input string text);
    fmt_row_t row;
    row.bits = bits;
    row.text = text;
    directed_rows.push_back(row);
  endfunction

  function automatic logic [63:0] random_double();
    logic        sign;
    logic [10:0] expf;
    logic [51:0] frac;
    logic [51:0] mask;
    int          offs;
    sign = 1'($urandom_range(0, 1));
    frac = 52'({$urandom, $urandom});
    expf = 11'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        return {$urandom, $urandom};
      end
      4: expf = 11'(ExpBias - 20 + int'($urandom_range(0, 40)));
      5: begin
        mask = (52'd1 << (4 * $urandom_range(0, 13))) - 52'd1;
        frac = frac & ~mask;
      end
      6: begin
        expf = 11'd0;
        if ($urandom_range(0, 3) == 0) frac = 52'd0;
      end
      7: begin
        expf = dthx_pkg::EXP_ALL_ONES;
        if ($urandom_range(0, 1) == 0) frac = 52'd0;
      end
      8: begin
        case ($urandom_range(0, 5))
          0: expf = 11'd1;
          1: expf = 11'd2;
          2: expf = 11'h7FE;
          3: expf = 11'h7FD;
          4: expf = 11'(ExpBias - 1);
          default: expf = 11'(ExpBias);
        endcase
      end
      default: begin
        // decimal exponent right around a digit-count boundary
        case ($urandom_range(0, 5))
          0: offs = 9;
          1: offs = 10;
          2: offs = 99;
          3: offs = 100;
          4: offs = 999;
          default: offs = 1000;
        endcase
        expf = ($urandom_range(0, 1) != 0) ? 11'(ExpBias + offs) : 11'(ExpBias - offs);
      end
    endcase
    return {sign, expf, frac};
  endfunction

  // hands one value to the block and records the text it should produce
  task automatic offer(input logic [63:0] bits, input string text);
    s_tvalid <= 1'b1;
    s_tdata  <= bits;
    do @(posedge clk); while (!s_tready);
    if (text.len() != 0) push_text(text);
    else spell_value(bits);
    @(negedge clk);
  endtask

  initial begin : sender
    fmt_row_t    row;
    logic [63:0] bits;
    string       text;
    int          burst_left;
    int          gap;
    int          total;
    add_row(64'h0000000000000000, "0x0.0P-1022");
    add_row(64'h8000000000000000, "-0x0.0P-1022");
    add_row(64'h7FF0000000000000, "infinity");
    add_row(64'hFFF0000000000000, "-infinity");
    add_row(64'h7FF8000000000000, "NaN");
    add_row(64'h7FF0000000000001, "NaN");
    add_row(64'hFFFFFFFFFFFFFFFF, "NaN");
    add_row(64'h3FF0000000000000, "0x1.0P+0");
    add_row(64'hBFF0000000000000, "-0x1.0P+0");
    add_row(64'h7FEFFFFFFFFFFFFF, "0x1.FFFFFFFFFFFFFP+1023");
    add_row(64'hFFEFFFFFFFFFFFFF, "-0x1.FFFFFFFFFFFFFP+1023");
    add_row(64'h0010000000000000, "0x1.0P-1022");
    add_row(64'h0000000000000001, "0x0.0000000000001P-1022");
    add_row(64'h000FFFFFFFFFFFFF, "0x0.FFFFFFFFFFFFFP-1022");
    add_row(64'h4000000000000000, "0x1.0P+1");
    add_row(64'h3FE0000000000000, "0x1.0P-1");
    add_row(64'h4090000000000000, "");
    add_row(64'h4634567890ABCDEF, "");
    add_row(64'h8170000000000000, "");
    add_row(64'h3FF8000000000000, "");
    add_row(64'h3FFA5A5A5A5A5A5A, "");
    add_row(64'h0008000000000000, "");
    add_row(64'hC3210FEDCBA98760, "");
    total = directed_rows.size() + RandomItems;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    burst_left = $urandom_range(1, 16);
    for (int n = 0; n < total; n++) begin
      if (n < directed_rows.size()) begin
        row  = directed_rows[n];
        bits = row.bits;
        text = row.text;
      end else begin
        bits = random_double();
        text = "";
      end
      offer(bits, text);
      burst_left--;
      if (burst_left == 0) begin
        case ($urandom_range(0, 9))
          0, 1, 2: gap = 0;
          3, 4, 5, 6, 7: gap = $urandom_range(1, 4);
          default: gap = $urandom_range(5, 30);
        endcase
        if (gap > 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst_left = $urandom_range(1, 16);
      end
    end
    s_tvalid <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS double_to_hex_text");
    end else begin
      $display("FAIL double_to_hex_text");
    end
    $finish;
  end

  // receiver stall pattern, with one long hold-off so the input side backs up
  initial begin : receiver
    int       cyc;
    rx_mode_t mode;
    cyc  = 0;
    mode = RX_OPEN;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 200 == 0) mode = rx_mode_t'($urandom_range(0, 3));
      if (cyc >= HoldStart && cyc < HoldStart + HoldCycles) begin
        m_tready <= 1'b0;
      end else begin
        case (mode)
          RX_OPEN:  m_tready <= 1'b1;
          RX_LIGHT: m_tready <= ($urandom_range(0, 7) != 0);
          RX_HEAVY: m_tready <= ($urandom_range(0, 2) == 0);
          default:  m_tready <= (cyc % 4 != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    text_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_chars.size() == 0) begin
        flag_error($sformatf("unexpected transaction: char %h last %b", m_tdata, m_tlast));
      end else begin
        want = pending_chars.pop_front();
        if (m_tdata !== {1'b0, want.ch} || m_tlast !== want.last) begin
          flag_error($sformatf("got char %h last %b, expected char %h last %b",
                               m_tdata, m_tlast, {1'b0, want.ch}, want.last));
        end
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("timeout with %0d characters outstanding", pending_chars.size());
    $display("FAIL double_to_hex_text");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/dthx_pkg.sv
hw/rtl/dthx_format.sv
hw/rtl/dthx_serial.sv
hw/rtl/double_to_hex_text.sv
test/double_to_hex_text_tb.sv
